/* hw/rtl/ipcs_pkg.sv */
package ipcs_pkg;

    // Words of the IPv4 header (20 bytes, no options)
    localparam int HEADER_WORDS = 10;

    localparam logic [15:0] HDR_WORDS_W    = 16'(HEADER_WORDS);
    localparam logic [15:0] HDR_PROTO_WORD = 16'd4;
    localparam logic [15:0] HDR_CSUM_WORD  = 16'd5;
    localparam logic [15:0] HDR_SRC_WORD   = 16'd6;
    localparam logic [15:0] HDR_DST_LAST   = 16'd9;

    // Old checksum position inside the segment, in words
    localparam logic [15:0] TCP_CSUM_WORD = 16'd8;
    localparam logic [15:0] UDP_CSUM_WORD = 16'd3;

    // Transport codes
    localparam logic [1:0] TRANSPORT_OTHER = 2'd0;
    localparam logic [1:0] TRANSPORT_TCP   = 2'd1;
    localparam logic [1:0] TRANSPORT_UDP   = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] ALL_ONES  = 16'hFFFF;

    typedef struct packed {
        logic [15:0] data;
        logic        last;
        logic        odd;
        logic [1:0]  transport;
    } ipcs_word_t;

    typedef struct packed {
        logic [15:0] ip_checksum;
        logic [15:0] l4_checksum;
        logic        l4_valid;
        logic        status;
    } ipcs_result_t;

endpackage

/* hw/rtl/ipcs_core.sv */
module ipcs_core
    import ipcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  ipcs_word_t   word,
    output ipcs_result_t result
);

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] hdr_sum_reg;
    logic [15:0] hdr_sum_next;
    logic [15:0] seg_sum_reg;
    logic [15:0] seg_sum_next;

    logic        in_header;
    logic [15:0] seg_idx;
    logic        skip;
    logic        odd_eff;
    logic [15:0] hdr_add;
    logic [15:0] seg_add;
    logic [15:0] l4_len;
    logic [17:0] fin_raw;
    logic [16:0] fin_fold;
    logic [15:0] fin_sum;
    logic [15:0] l4_cpl;

    // one's-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

    assign in_header = count_reg < HDR_WORDS_W;
    assign seg_idx   = count_reg - HDR_WORDS_W;
    assign skip      = ((word.transport == TRANSPORT_TCP) && (seg_idx == TCP_CSUM_WORD))
                    || ((word.transport == TRANSPORT_UDP) && (seg_idx == UDP_CSUM_WORD));
    assign odd_eff   = !in_header && word.last && word.odd;

    // pick the contribution of this word to each sum
    always_comb
    begin
        hdr_add = 16'd0;
        seg_add = 16'd0;
        if (in_header)
        begin
            if (count_reg != HDR_CSUM_WORD)
            begin
                hdr_add = word.data;
            end
            if (count_reg == HDR_PROTO_WORD)
            begin
                seg_add = {8'd0, word.data[7:0]};
            end
            else if ((count_reg >= HDR_SRC_WORD) && (count_reg <= HDR_DST_LAST))
            begin
                seg_add = word.data;
            end
        end
        else if (!skip)
        begin
            seg_add = odd_eff ? {word.data[15:8], 8'd0} : word.data;
        end
    end

    // saturate the word count
    assign count_next   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;
    assign hdr_sum_next = oc_add(hdr_sum_reg, hdr_add);
    assign seg_sum_next = oc_add(seg_sum_reg, seg_add);

    // L4 length in bytes from the updated count
    assign l4_len = ((count_next - HDR_WORDS_W) << 1) - {15'd0, odd_eff};

    // segment sum, this word and length in one three-input fold
    assign fin_raw  = {2'd0, seg_sum_reg} + {2'd0, seg_add} + {2'd0, l4_len};
    assign fin_fold = {1'b0, fin_raw[15:0]} + {15'd0, fin_raw[17:16]};
    assign fin_sum  = fin_fold[15:0] + {15'd0, fin_fold[16]};
    assign l4_cpl   = ~fin_sum;

    // build the result for a last word
    always_comb
    begin
        result = '0;
        if (count_next < HDR_WORDS_W)
        begin
            result.status = 1'b1;
        end
        else
        begin
            result.ip_checksum = ~hdr_sum_next;
            if ((word.transport == TRANSPORT_TCP) || (word.transport == TRANSPORT_UDP))
            begin
                result.l4_checksum = (l4_cpl == 16'd0) ? ALL_ONES : l4_cpl;
                result.l4_valid    = 1'b1;
            end
        end
    end

    // advance the running state; clear after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 16'd0;
            hdr_sum_reg <= 16'd0;
            seg_sum_reg <= 16'd0;
        end
        else if (step)
        begin
            if (word.last)
            begin
                count_reg   <= 16'd0;
                hdr_sum_reg <= 16'd0;
                seg_sum_reg <= 16'd0;
            end
            else
            begin
                count_reg   <= count_next;
                hdr_sum_reg <= hdr_sum_next;
                seg_sum_reg <= seg_sum_next;
            end
        end
    end

endmodule

/* hw/rtl/ipv4_tcp_udp_checksum.sv */
// IPv4 header and TCP/UDP checksum generator.
// Input channel (in_valid/in_ready): one 16-bit packet word per transfer in
// network byte order, with last_word marking the end of the packet, odd_byte
// marking a final word that carries only its high byte, and transport
// (0 other, 1 TCP, 2 UDP) held constant within a packet.
// Output channel (out_valid/out_ready): one word per packet, given for its
// last input word: header checksum, TCP/UDP checksum, l4_valid and status
// (1 when the packet ended inside the 20-byte IPv4 header).
// Throughput: one input word per cycle unless a last word meets a stalled
// receiver, from a single one's-complement add per sum between the input
// register and the result register. The input register feeds the output
// register, which loads a result when the held last word advances.
// When the receiver stalls, the output register holds its result; non-last
// words keep flowing, and a last word waits in the input register, holding
// in_ready low, until the output register frees.
// Reset clears the word counter, both running sums and both valid flags.
module ipv4_tcp_udp_checksum
    import ipcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] data_word,
    input  logic        last_word,
    input  logic        odd_byte,
    input  logic [1:0]  transport,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] ip_checksum,
    output logic [15:0] l4_checksum,
    output logic        l4_valid,
    output logic        status
);

    logic         in_valid_reg;
    logic         in_valid_next;
    ipcs_word_t   word_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    ipcs_result_t result_reg;
    ipcs_result_t core_result;
    logic         advance;
    logic         in_take;

    // move the held word into the sums unless its result cannot be stored
    assign advance  = in_valid_reg && (!word_reg.last || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    ipcs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (word_reg),
        .result (core_result)
    );

    // input register
    assign in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg <= '{data: data_word, last: last_word, odd: odd_byte,
                          transport: transport};
        end
    end

    // output register: load on a last word, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && word_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && word_reg.last)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ip_checksum = result_reg.ip_checksum;
    assign l4_checksum = result_reg.l4_checksum;
    assign l4_valid    = result_reg.l4_valid;
    assign status      = result_reg.status;

    // a short packet carries no checksums
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !l4_valid && ip_checksum == 16'd0 && l4_checksum == 16'd0)
        else $error("short packet result carries checksum data");

    // a valid L4 checksum is never zero
    a_l4_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && l4_valid |-> l4_checksum != 16'd0)
        else $error("L4 checksum of zero was emitted");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_reg))
        else $error("stalled result changed");

    // a held last word waits only for the output register
    a_last_wait: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> word_reg.last && out_valid && !out_ready)
        else $error("input register stalled without cause");

endmodule
